FILE: hw/rtl/pwfr_pkg.sv
// Package for the pulse width frame receiver: frame geometry, field widths,
// status and register index codes, and the structs passed between modules.
// Depends on nothing; RTL files use scoped names, the testbench imports it.
package pwfr_pkg;

   localparam int FRAME_BYTES = 7;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int BYTE_SEL_W  = $clog2(FRAME_BYTES);
   localparam int BITPOS_W    = BYTE_SEL_W + 3;

   localparam int CNT_W      = 20;
   localparam int SHORT_W    = 6;
   localparam int SINCE_W    = 22;
   localparam int FAIL_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int BYTE_IDX_W = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
   localparam logic [FAIL_W-1:0]  FAIL_MAX  = '1;

   localparam logic [BITPOS_W-1:0]   LAST_BIT  = BITPOS_W'(FRAME_BITS - 1);
   localparam logic [BYTE_SEL_W-1:0] LAST_BYTE = BYTE_SEL_W'(FRAME_BYTES - 1);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_GOOD        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PREAMBLE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT     = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THRESH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SHORT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HUNT_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TIMEOUT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_WINDOW  = 3'd5;

   // configuration reset values
   localparam logic [CNT_W-1:0]   RST_PREAMBLE_MIN = 20'd7000;
   localparam logic [CNT_W-1:0]   RST_ONE_THRESH   = 20'd1200;
   localparam logic [SHORT_W-1:0] RST_MAX_SHORT    = 6'd60;
   localparam logic [CNT_W-1:0]   RST_HUNT_TIMEOUT = 20'd20000;
   localparam logic [CNT_W-1:0]   RST_BIT_TIMEOUT  = 20'd1000000;
   localparam logic [SINCE_W-1:0] RST_SYNC_WINDOW  = 22'd3000000;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic [CNT_W-1:0]   preamble_min;
      logic [CNT_W-1:0]   one_thresh;
      logic [SHORT_W-1:0] max_short;
      logic [CNT_W-1:0]   hunt_timeout;
      logic [CNT_W-1:0]   bit_timeout;
      logic [SINCE_W-1:0] sync_window;
   } cfg_type;

   // one frame event: a good frame (several result items) or one failure item
   typedef struct packed {
      logic                good;
      logic [STATUS_W-1:0] status;
      logic                synced;
      logic [FAIL_W-1:0]   fails;
      frame_type           data;
   } event_type;

endpackage

FILE: hw/rtl/pulse_width_frame_receiver.sv
// Top level of the pulse width frame receiver: configuration registers, the
// per-tick receive core and the result emitter. Depends on pwfr_pkg,
// pwfr_csr, pwfr_core and pwfr_emit.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_line_level
//   rsp_      out        rsp_valid/rsp_ready  status, byte_value, byte_index,
//                                             last, synchronized, failed_frames
//   csr_      in         csr_wr_en            csr_index, csr_wr_data
//
// One line sample is taken per cycle while req_ready is high; the core
// updates all receive state in the cycle it accepts a sample. A result
// passes the waiting slot, then the output register, to the rsp_ port. A
// good frame plays out of the output register as FRAME_BYTES items, one
// per cycle while rsp_ready is high; a failure is a single item. One event
// waits in a slot behind the output register; req_ready drops only while
// that slot is full and cannot move on. Synchronous reset, no clearing pass.
module pulse_width_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_line_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pwfr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [7:0]                          rsp_byte_value,
   output logic [pwfr_pkg::BYTE_IDX_W-1:0]     rsp_byte_index,
   output logic                                rsp_last,
   output logic                                rsp_synchronized,
   output logic [pwfr_pkg::FAIL_W-1:0]         rsp_failed_frames,
   input  logic                                csr_wr_en,
   input  logic [pwfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwfr_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   pwfr_pkg::cfg_type    cfg;
   pwfr_pkg::event_type  ev;
   logic                 ev_push;
   logic                 slot_ready;
   logic                 accept;

   assign req_ready = slot_ready;
   assign accept    = req_valid && slot_ready;

   pwfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pwfr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .line_level (req_line_level),
      .ev_push    (ev_push),
      .ev         (ev)
   );

   pwfr_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .ev_push           (ev_push),
      .ev                (ev),
      .slot_ready        (slot_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last          (rsp_last),
      .rsp_synchronized  (rsp_synchronized),
      .rsp_failed_frames (rsp_failed_frames)
   );

endmodule

FILE: hw/rtl/pwfr_csr.sv
// Configuration registers of the pulse width frame receiver.
// Depends on pwfr_pkg for widths, index codes and reset values.
module pwfr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [pwfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwfr_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output pwfr_pkg::cfg_type                 cfg
);

   pwfr_pkg::cfg_type cfg_ff;
   pwfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pwfr_pkg::CSR_PREAMBLE_MIN:
               cfg_in.preamble_min = csr_wr_data[pwfr_pkg::CNT_W-1:0];
            pwfr_pkg::CSR_ONE_THRESH:
               cfg_in.one_thresh = csr_wr_data[pwfr_pkg::CNT_W-1:0];
            pwfr_pkg::CSR_MAX_SHORT:
               cfg_in.max_short = csr_wr_data[pwfr_pkg::SHORT_W-1:0];
            pwfr_pkg::CSR_HUNT_TIMEOUT:
               cfg_in.hunt_timeout = csr_wr_data[pwfr_pkg::CNT_W-1:0];
            pwfr_pkg::CSR_BIT_TIMEOUT:
               cfg_in.bit_timeout = csr_wr_data[pwfr_pkg::CNT_W-1:0];
            pwfr_pkg::CSR_SYNC_WINDOW:
               cfg_in.sync_window = csr_wr_data[pwfr_pkg::SINCE_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_min <= pwfr_pkg::RST_PREAMBLE_MIN;
         cfg_ff.one_thresh   <= pwfr_pkg::RST_ONE_THRESH;
         cfg_ff.max_short    <= pwfr_pkg::RST_MAX_SHORT;
         cfg_ff.hunt_timeout <= pwfr_pkg::RST_HUNT_TIMEOUT;
         cfg_ff.bit_timeout  <= pwfr_pkg::RST_BIT_TIMEOUT;
         cfg_ff.sync_window  <= pwfr_pkg::RST_SYNC_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/pwfr_core.sv
// Per-tick pulse measurement, frame hunt and bit decode of the receiver.
// Updates all receive state on each accepted sample and raises one frame
// event per good frame or failure. Depends on pwfr_pkg.
module pwfr_core (
   input  logic                   clock,
   input  logic                   reset,
   input  pwfr_pkg::cfg_type      cfg,
   input  logic                   accept,
   input  logic                   line_level,
   output logic                   ev_push,
   output pwfr_pkg::event_type    ev
);

   typedef enum logic {PH_HUNT, PH_RECEIVE} phase_type;

   phase_type                         phase_ff,  phase_in;
   logic                              prev_ff,   prev_in;
   logic [pwfr_pkg::CNT_W-1:0]        low_ff,    low_in;
   logic [pwfr_pkg::CNT_W-1:0]        el_ff,     el_in;
   logic [pwfr_pkg::SHORT_W-1:0]      short_ff,  short_in;
   logic [pwfr_pkg::BITPOS_W-1:0]     bitpos_ff, bitpos_in;
   pwfr_pkg::frame_type               store_ff,  store_in;
   logic [7:0]                        sum_ff,    sum_in;
   logic [pwfr_pkg::SINCE_W-1:0]      since_ff,  since_in;
   logic [pwfr_pkg::FAIL_W-1:0]       fail_ff,   fail_in;

   logic [pwfr_pkg::CNT_W-1:0]        el_step;
   logic [pwfr_pkg::CNT_W-1:0]        low_base;
   logic [pwfr_pkg::CNT_W-1:0]        limit;
   logic [pwfr_pkg::BYTE_SEL_W-1:0]   byte_sel;
   logic                              rise;
   logic                              good_hit;
   logic                              fail_hit;
   logic [pwfr_pkg::STATUS_W-1:0]     fail_code;

   assign rise     = !prev_ff && line_level;
   assign el_step  = (el_ff != pwfr_pkg::CNT_MAX) ? el_ff + 1'b1 : el_ff;
   assign limit    = (phase_ff == PH_HUNT) ? cfg.hunt_timeout : cfg.bit_timeout;
   assign byte_sel = bitpos_ff[pwfr_pkg::BITPOS_W-1:3];

   always_comb begin
      phase_in  = phase_ff;
      short_in  = short_ff;
      bitpos_in = bitpos_ff;
      store_in  = store_ff;
      sum_in    = sum_ff;
      fail_in   = fail_ff;
      since_in  = (since_ff != pwfr_pkg::SINCE_MAX) ? since_ff + 1'b1 : since_ff;
      el_in     = el_step;
      low_base  = low_ff;
      good_hit  = 1'b0;
      fail_hit  = 1'b0;
      fail_code = pwfr_pkg::STATUS_TIMEOUT;

      if (rise) begin
         low_base = '0;
         el_in    = '0;
         if (phase_ff == PH_HUNT) begin
            if (low_ff >= cfg.preamble_min) begin
               phase_in  = PH_RECEIVE;
               bitpos_in = '0;
               short_in  = '0;
               store_in  = '0;
               sum_in    = '0;
            end else if (({1'b0, short_ff} + 1'b1) > {1'b0, cfg.max_short}) begin
               fail_hit  = 1'b1;
               fail_code = pwfr_pkg::STATUS_NO_PREAMBLE;
            end else begin
               short_in = short_ff + 1'b1;
            end
         end else begin
            if (low_ff > cfg.one_thresh) begin
               store_in[byte_sel][bitpos_ff[2:0]] = 1'b1;
               // keep a running checksum of every byte but the last
               if (byte_sel != pwfr_pkg::LAST_BYTE) begin
                  sum_in = sum_ff + (8'd1 << bitpos_ff[2:0]);
               end
            end
            bitpos_in = bitpos_ff + 1'b1;
            if (bitpos_ff == pwfr_pkg::LAST_BIT) begin
               if (sum_ff == store_in[pwfr_pkg::FRAME_BYTES-1]) begin
                  good_hit = 1'b1;
               end else begin
                  fail_hit  = 1'b1;
                  fail_code = pwfr_pkg::STATUS_CHECKSUM;
               end
            end
         end
      end else if (el_step >= limit) begin
         fail_hit = 1'b1;
      end

      if (good_hit) begin
         fail_in  = '0;
         since_in = '0;
      end
      if (fail_hit) begin
         fail_in = (fail_ff != pwfr_pkg::FAIL_MAX) ? fail_ff + 1'b1 : fail_ff;
      end
      if (good_hit || fail_hit) begin
         phase_in  = PH_HUNT;
         short_in  = '0;
         bitpos_in = '0;
         el_in     = '0;
         low_base  = '0;
      end

      low_in  = (!line_level && low_base != pwfr_pkg::CNT_MAX) ? low_base + 1'b1 : low_base;
      prev_in = line_level;
   end

   always_comb begin
      ev_push   = accept && (good_hit || fail_hit);
      ev.good   = good_hit;
      ev.status = good_hit ? pwfr_pkg::STATUS_GOOD : fail_code;
      ev.synced = since_in < cfg.sync_window;
      ev.fails  = fail_in;
      ev.data   = good_hit ? store_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         prev_ff   <= 1'b1;
         low_ff    <= '0;
         el_ff     <= '0;
         short_ff  <= '0;
         bitpos_ff <= '0;
         store_ff  <= '0;
         sum_ff    <= '0;
         since_ff  <= '0;
         fail_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         low_ff    <= low_in;
         el_ff     <= el_in;
         short_ff  <= short_in;
         bitpos_ff <= bitpos_in;
         store_ff  <= store_in;
         sum_ff    <= sum_in;
         since_ff  <= since_in;
         fail_ff   <= fail_in;
      end
   end

endmodule

FILE: hw/rtl/pwfr_emit.sv
// Result side of the receiver: one waiting event slot and the output register
// that plays an event out as one failure item or a run of frame bytes.
// Depends on pwfr_pkg.
module pwfr_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                ev_push,
   input  pwfr_pkg::event_type                 ev,
   output logic                                slot_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pwfr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [7:0]                          rsp_byte_value,
   output logic [pwfr_pkg::BYTE_IDX_W-1:0]     rsp_byte_index,
   output logic                                rsp_last,
   output logic                                rsp_synchronized,
   output logic [pwfr_pkg::FAIL_W-1:0]         rsp_failed_frames
);

   logic                              slot_valid_ff, slot_valid_in;
   pwfr_pkg::event_type               slot_ff;
   logic                              cur_valid_ff,  cur_valid_in;
   pwfr_pkg::event_type               cur_ff,        cur_in;
   logic [pwfr_pkg::BYTE_SEL_W-1:0]   idx_ff,        idx_in;

   logic cur_last;
   logic rsp_fire;
   logic cur_free;
   logic slot_take;

   assign cur_last   = !cur_ff.good || (idx_ff == pwfr_pkg::LAST_BYTE);
   assign rsp_fire   = cur_valid_ff && rsp_ready;
   assign cur_free   = !cur_valid_ff || (rsp_fire && cur_last);
   assign slot_take  = slot_valid_ff && cur_free;
   assign slot_ready = !slot_valid_ff || slot_take;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (ev_push) begin
         slot_valid_in = 1'b1;
      end else if (slot_take) begin
         slot_valid_in = 1'b0;
      end

      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      if (cur_free) begin
         cur_valid_in = slot_valid_ff;
         cur_in       = slot_ff;
         idx_in       = '0;
      end else if (rsp_fire) begin
         // advance to the next frame byte
         cur_in.data = pwfr_pkg::frame_type'(cur_ff.data >> 8);
         idx_in      = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         cur_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         cur_valid_ff  <= cur_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_push) begin
         slot_ff <= ev;
      end
      cur_ff <= cur_in;
   end

   assign rsp_valid         = cur_valid_ff;
   assign rsp_status        = cur_ff.status;
   assign rsp_byte_value    = cur_ff.data[0];
   assign rsp_byte_index    = pwfr_pkg::BYTE_IDX_W'(idx_ff);
   assign rsp_last          = cur_last;
   assign rsp_synchronized  = cur_ff.synced;
   assign rsp_failed_frames = cur_ff.fails;

endmodule

FILE: tb/tb_pulse_width_frame_receiver.sv
// Self-checking testbench for pulse_width_frame_receiver: line samples go in
// through a queue-fed driver, results are compared against a cycle-free predictor.
// Depends on pwfr_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module tb_pulse_width_frame_receiver;
   import pwfr_pkg::*;

   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned MAX_PRINTED     = 40;
   localparam realtime     RUN_LIMIT       = 3_000_000ns;

   typedef enum logic {HUNTING, IN_FRAME} rx_phase_e;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [7:0]            byte_value;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic                  last;
      logic                  synced;
      logic [FAIL_W-1:0]     fails;
   } rsp_item_t;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_line_level;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [STATUS_W-1:0]     rsp_status;
   logic [7:0]              rsp_byte_value;
   logic [BYTE_IDX_W-1:0]   rsp_byte_index;
   logic                    rsp_last;
   logic                    rsp_synchronized;
   logic [FAIL_W-1:0]       rsp_failed_frames;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wr_data;

   pulse_width_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_line_level    (req_line_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last          (rsp_last),
      .rsp_synchronized  (rsp_synchronized),
      .rsp_failed_frames (rsp_failed_frames),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // stimulus and bookkeeping
   logic        line_samples[$];
   rsp_item_t   due_results[$];
   logic        req_taken;
   int unsigned sender_idle_pct;
   int unsigned rsp_stall_pct;
   bit          hold_off_go;
   bit          rsp_hold;
   int unsigned queued_items;
   int unsigned accepted_items;
   int unsigned predicted_rsp;
   int unsigned checked_rsp;
   int unsigned good_frames;
   int unsigned fail_events;
   int unsigned setups;
   int unsigned mismatches;

   // receiver state as the predictor sees it
   cfg_type            rx_cfg;
   rx_phase_e          rx_phase;
   logic               prev_level;
   logic [CNT_W-1:0]   low_ticks;
   logic [CNT_W-1:0]   elapsed_ticks;
   logic [SHORT_W-1:0] short_count;
   int unsigned        bit_pos;
   frame_type          frame_store;
   logic [SINCE_W-1:0] since_good;
   logic [FAIL_W-1:0]  fail_count;

   task automatic flag_mismatch(input string msg);
      if (mismatches < MAX_PRINTED)
         $display("[%0t] MISMATCH on result %0d: %s", $realtime, checked_rsp, msg);
      mismatches++;
   endtask

   function automatic void queue_rsp(input logic [STATUS_W-1:0] st, input logic [7:0] val,
                                     input logic [BYTE_IDX_W-1:0] idx, input logic lst);
      rsp_item_t item;
      item.status     = st;
      item.byte_value = val;
      item.byte_index = idx;
      item.last       = lst;
      item.synced     = (since_good < rx_cfg.sync_window);
      item.fails      = fail_count;
      due_results.push_back(item);
      predicted_rsp++;
   endfunction

   function automatic void restart_hunt();
      rx_phase      = HUNTING;
      short_count   = '0;
      bit_pos       = 0;
      elapsed_ticks = '0;
      low_ticks     = '0;
   endfunction

   function automatic void frame_failed(input logic [STATUS_W-1:0] st);
      if (fail_count != FAIL_MAX)
         fail_count++;
      restart_hunt();
      queue_rsp(st, 8'd0, '0, 1'b1);
   endfunction

   function automatic void reset_predictor();
      rx_cfg.preamble_min = RST_PREAMBLE_MIN;
      rx_cfg.one_thresh   = RST_ONE_THRESH;
      rx_cfg.max_short    = RST_MAX_SHORT;
      rx_cfg.hunt_timeout = RST_HUNT_TIMEOUT;
      rx_cfg.bit_timeout  = RST_BIT_TIMEOUT;
      rx_cfg.sync_window  = RST_SYNC_WINDOW;
      rx_phase      = HUNTING;
      prev_level    = 1'b1;
      low_ticks     = '0;
      elapsed_ticks = '0;
      short_count   = '0;
      bit_pos       = 0;
      frame_store   = '0;
      since_good    = '0;
      fail_count    = '0;
   endfunction

   // One tick of the receiver; queues whatever results the sample causes.
   function automatic void track_line_sample(input logic level);
      logic [CNT_W-1:0] pulse_len;
      logic [CNT_W-1:0] limit;
      logic [7:0]       sum;
      if (since_good != SINCE_MAX)
         since_good++;
      if (elapsed_ticks != CNT_MAX)
         elapsed_ticks++;
      if (!prev_level && level) begin
         pulse_len     = low_ticks;
         low_ticks     = '0;
         elapsed_ticks = '0;
         if (rx_phase == HUNTING) begin
            if (pulse_len >= rx_cfg.preamble_min) begin
               rx_phase    = IN_FRAME;
               bit_pos     = 0;
               short_count = '0;
               frame_store = '0;
            end else if (int'(short_count) + 1 > int'(rx_cfg.max_short)) begin
               frame_failed(STATUS_NO_PREAMBLE);
            end else begin
               short_count++;
            end
         end else begin
            if (bit_pos < FRAME_BITS && pulse_len > rx_cfg.one_thresh)
               frame_store[bit_pos / 8][bit_pos % 8] = 1'b1;
            bit_pos++;
            if (bit_pos >= FRAME_BITS) begin
               sum = '0;
               for (int i = 0; i < FRAME_BYTES - 1; i++)
                  sum = sum + frame_store[i];
               if (sum == frame_store[FRAME_BYTES-1]) begin
                  fail_count = '0;
                  since_good = '0;
                  restart_hunt();
                  for (int i = 0; i < FRAME_BYTES; i++)
                     queue_rsp(STATUS_GOOD, frame_store[i], BYTE_IDX_W'(i),
                               i == FRAME_BYTES - 1);
               end else begin
                  frame_failed(STATUS_CHECKSUM);
               end
            end
         end
      end else begin
         limit = (rx_phase == HUNTING) ? rx_cfg.hunt_timeout : rx_cfg.bit_timeout;
         if (elapsed_ticks >= limit)
            frame_failed(STATUS_TIMEOUT);
      end
      if (!level && low_ticks != CNT_MAX)
         low_ticks++;
      prev_level = level;
   endfunction

   function automatic void push_level(input logic level, input int unsigned count);
      repeat (count) begin
         line_samples.push_back(level);
         queued_items++;
      end
   endfunction

   function automatic void push_pulse(input int unsigned low_len, input int unsigned high_len);
      push_level(1'b0, low_len);
      push_level(1'b1, high_len);
   endfunction

   // preamble, then nbits pulses carrying data LSB first
   function automatic void push_frame(input frame_type data, input int unsigned nbits);
      push_pulse(rx_cfg.preamble_min + $urandom_range(0, 2), $urandom_range(1, 2));
      for (int unsigned b = 0; b < nbits; b++) begin
         if (data[b / 8][b % 8])
            push_pulse(rx_cfg.one_thresh + $urandom_range(1, 2), $urandom_range(1, 2));
         else
            push_pulse($urandom_range(1, rx_cfg.one_thresh), $urandom_range(1, 2));
      end
   endfunction

   function automatic void push_random_sequence();
      frame_type   data;
      logic [7:0]  sum;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      push_level(1'b1, $urandom_range(1, 3));
      if (pick < 70) begin
         sum = '0;
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            data[i] = 8'($urandom);
            sum     = sum + data[i];
         end
         data[FRAME_BYTES-1] = sum;
         if ($urandom_range(0, 4) == 0)
            data[FRAME_BYTES-1] ^= 8'($urandom_range(1, 255));
         if (pick < 58) begin
            push_frame(data, FRAME_BITS);
         end else begin
            // cut the frame short and let the bit timer expire
            push_frame(data, $urandom_range(0, FRAME_BITS - 1));
            push_level(1'b1, rx_cfg.bit_timeout + $urandom_range(0, 2));
         end
      end else if (pick < 82) begin
         repeat ($urandom_range(1, rx_cfg.max_short + 2))
            push_pulse($urandom_range(1, rx_cfg.preamble_min - 1), $urandom_range(1, 2));
      end else if (pick < 90) begin
         push_level(1'b1, rx_cfg.hunt_timeout + $urandom_range(0, 3));
      end else begin
         repeat ($urandom_range(1, 12))
            push_level(1'($urandom), 1);
         push_level(1'b1, rx_cfg.bit_timeout + 1);
      end
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.one_thresh   = CNT_W'($urandom_range(1, 3));
      c.preamble_min = c.one_thresh + CNT_W'($urandom_range(3, 6));
      c.max_short    = SHORT_W'($urandom_range(2, 8));
      c.bit_timeout  = c.one_thresh + CNT_W'($urandom_range(4, 8));
      c.hunt_timeout = c.preamble_min + CNT_W'($urandom_range(8, 14));
      c.sync_window  = SINCE_W'($urandom_range(1, 400));
      return c;
   endfunction

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
   endtask

   // only call while the block is idle
   task automatic program_regs(input cfg_type c);
      put_reg(CSR_PREAMBLE_MIN, CSR_DATA_W'(c.preamble_min));
      put_reg(CSR_ONE_THRESH,   CSR_DATA_W'(c.one_thresh));
      put_reg(CSR_MAX_SHORT,    CSR_DATA_W'(c.max_short));
      put_reg(CSR_HUNT_TIMEOUT, CSR_DATA_W'(c.hunt_timeout));
      put_reg(CSR_BIT_TIMEOUT,  CSR_DATA_W'(c.bit_timeout));
      put_reg(CSR_SYNC_WINDOW,  CSR_DATA_W'(c.sync_window));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      rx_cfg = c;
      setups++;
   endtask

   task automatic drain_and_settle();
      while (line_samples.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      int unsigned items_start;
      int unsigned rsp_start;
      program_regs(random_cfg());
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      items_start     = queued_items;
      rsp_start       = predicted_rsp;
      while ((queued_items - items_start < 60 || predicted_rsp - rsp_start < 15) &&
             queued_items - items_start < 1500) begin
         push_random_sequence();
         while (line_samples.size() > 16)
            @(posedge clock);
      end
      drain_and_settle();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Run did not finish in time: %0d results still due", due_results.size());
      $display("Some tests failed");
      $finish;
   end

   // long output hold-off so the block backs up and drops req_ready
   initial begin
      rsp_hold = 1'b0;
      wait (hold_off_go);
      rsp_hold = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (line_samples.size() != 0 && $urandom_range(1, 100) > sender_idle_pct) begin
            req_valid      <= 1'b1;
            req_line_level <= line_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !rsp_hold && ($urandom_range(1, 100) > rsp_stall_pct);

   always @(posedge clock) begin : monitor
      rsp_item_t want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               flag_mismatch($sformatf("unexpected result, status %0d byte %0d",
                                       rsp_status, rsp_byte_value));
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_byte_value !== want.byte_value)
                  flag_mismatch($sformatf("byte_value %0d, expected %0d",
                                          rsp_byte_value, want.byte_value));
               if (rsp_byte_index !== want.byte_index)
                  flag_mismatch($sformatf("byte_index %0d, expected %0d",
                                          rsp_byte_index, want.byte_index));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
               if (rsp_synchronized !== want.synced)
                  flag_mismatch($sformatf("synchronized %0d, expected %0d",
                                          rsp_synchronized, want.synced));
               if (rsp_failed_frames !== want.fails)
                  flag_mismatch($sformatf("failed_frames %0d, expected %0d",
                                          rsp_failed_frames, want.fails));
            end
            if (rsp_status == STATUS_GOOD && rsp_last)
               good_frames++;
            else if (rsp_status != STATUS_GOOD)
               fail_events++;
            checked_rsp++;
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            accepted_items++;
            track_line_sample(req_line_level);
         end
      end
   end

   initial begin : stimulus
      cfg_type c;
      req_valid       = 1'b0;
      req_line_level  = 1'b1;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wr_data     = '0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_off_go     = 1'b0;
      req_taken       = 1'b0;
      queued_items    = 0;
      accepted_items  = 0;
      predicted_rsp   = 0;
      checked_rsp     = 0;
      good_frames     = 0;
      fail_events     = 0;
      setups          = 0;
      mismatches      = 0;
      reset_predictor();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: one short pulse is merely counted
      push_level(1'b1, 1);
      push_pulse(2, 2);
      drain_and_settle();

      // no short pulses allowed, zero hunt timeout fires on every quiet tick
      c = rx_cfg;
      c.max_short    = '0;
      c.hunt_timeout = '0;
      c.sync_window  = SINCE_W'(1);
      program_regs(c);
      push_pulse(1, 2);
      drain_and_settle();

      // zero preamble starts a frame on any pulse, zero bit timeout drops it
      c.preamble_min = '0;
      c.bit_timeout  = '0;
      c.hunt_timeout = CNT_MAX;
      c.max_short    = SHORT_W'(63);
      c.one_thresh   = CNT_W'(1);
      c.sync_window  = SINCE_MAX;
      program_regs(c);
      push_pulse(1, 2);
      push_pulse(2, 1);
      drain_and_settle();

      run_random_phase(0, 0);
      run_random_phase(81, 0);
      run_random_phase(0, 81);
      run_random_phase(30, 30);
      run_random_phase(0, 0);

      // full-scale registers: 64 short pulses are needed before the no-preamble failure
      c.preamble_min = CNT_MAX;
      c.one_thresh   = CNT_MAX;
      c.max_short    = SHORT_W'(63);
      c.hunt_timeout = CNT_MAX;
      c.bit_timeout  = CNT_MAX;
      c.sync_window  = SINCE_MAX;
      program_regs(c);
      sender_idle_pct = 30;
      rsp_stall_pct   = 30;
      push_level(1'b1, 2);
      repeat (140)
         push_pulse($urandom_range(1, 3), 1);
      drain_and_settle();

      // minimum registers: nearly every sample fails, so hold the output and back up
      c.preamble_min = CNT_W'(1);
      c.one_thresh   = CNT_W'(1);
      c.max_short    = '0;
      c.hunt_timeout = CNT_W'(1);
      c.bit_timeout  = CNT_W'(1);
      c.sync_window  = SINCE_W'(1);
      program_regs(c);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      @(posedge clock);
      hold_off_go = 1'b1;
      repeat (320)
         push_level($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1, 1);
      drain_and_settle();

      $display("Summary: %0d line samples under %0d register setups, zero and full scale included",
               accepted_items, setups);
      $display("Summary: %0d results checked (%0d good frames, %0d failure events), with stalls",
               checked_rsp, good_frames, fail_events);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
